[rtl/core/pbi_pkg.sv]
// ----------------------------------------------------------------------------
// pbi_pkg
// Types, constants and helpers for the palette builder and indexer.
// ----------------------------------------------------------------------------
package pbi_pkg;

	localparam int unsigned COLOR_W = 32;
	localparam int unsigned IDX_W   = 8;
	localparam int unsigned CNT_W   = 9;

	localparam logic [IDX_W-1:0] MISS_INDEX = 8'hFF;

	localparam logic FMT_DIRECT  = 1'b0;
	localparam logic FMT_INDEXED = 1'b1;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	typedef enum logic [1:0] {
		OP_DIRECT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_READ   = 2'd2
	} op_t;

	typedef struct packed {
		logic                command;
		logic                start_of_image;
		logic [COLOR_W-1:0]  pixel_color;
		logic [IDX_W-1:0]    slot;
	} pix_t;

	typedef struct packed {
		logic [IDX_W-1:0]    pixel_index;
		logic                pixel_missed;
		logic [COLOR_W-1:0]  color_out;
		logic [CNT_W-1:0]    color_count;
	} res_t;

	// token that walks the cell chain
	typedef struct packed {
		logic                valid;
		op_t                 op;
		logic                found;
		logic                inserted;
		logic [IDX_W-1:0]    idx;
		logic [COLOR_W-1:0]  color;
	} tok_t;

	function automatic logic [COLOR_W-1:0] halve_channels(input logic [COLOR_W-1:0] c);
		return (c >> 1) & 32'h7F7F7F7F;
	endfunction

	// clut position to palette entry: bits 4:3 patterns 01 and 10 trade places
	function automatic logic [IDX_W-1:0] clut_to_entry(input logic [IDX_W-1:0] pos);
		return {pos[7:5], pos[3], pos[4], pos[2:0]};
	endfunction

endpackage

[rtl/core/pbi_cell.sv]
// ----------------------------------------------------------------------------
// pbi_cell
// One palette cell: holds one color and its valid bit, matches, inserts or
// reads for the token passing through and hands the token on.
// ----------------------------------------------------------------------------
module pbi_cell import pbi_pkg::*; #(
	parameter int unsigned POS = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  logic clear,
	input  tok_t tok_in,
	output tok_t tok_out
);

	localparam logic [IDX_W-1:0] POS_IDX = IDX_W'(POS);

	logic               valid_q;
	logic [COLOR_W-1:0] color_q;
	tok_t               tok_q;
	tok_t               tok_nxt;
	logic               is_lookup;
	logic               hit;
	logic               ins;
	logic               rd_hit;

	always_comb begin
		is_lookup = tok_in.valid && (tok_in.op == OP_LOOKUP) && !tok_in.found;
		hit       = is_lookup && valid_q && (color_q == tok_in.color);
		ins       = is_lookup && !valid_q;
		rd_hit    = tok_in.valid && (tok_in.op == OP_READ) && valid_q &&
		            (tok_in.idx == POS_IDX);
		tok_nxt   = tok_in;
		if (hit || ins) begin
			tok_nxt.found = 1'b1;
			tok_nxt.idx   = POS_IDX;
		end
		if (ins) begin
			tok_nxt.inserted = 1'b1;
		end
		if (rd_hit) begin
			tok_nxt.found = 1'b1;
			tok_nxt.color = color_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			if (clear) begin
				valid_q <= 1'b0;
			end else if (advance && ins) begin
				valid_q <= 1'b1;
			end
			if (advance) begin
				tok_q <= tok_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && ins) begin
			color_q <= tok_in.color;
		end
	end

	assign tok_out = tok_q;

endmodule

[rtl/core/palette_builder_indexer_top.sv]
// ----------------------------------------------------------------------------
// palette_builder_indexer_top
// Palette builder and indexer for 32-bit RGBA pixels.
// ----------------------------------------------------------------------------
// Each item becomes a token that walks a chain of PALETTE_ENTRIES cells, one
// cell per cycle unless a held result stalls the chain; every cell holds one
// palette color and matches, appends or reads as the token passes. One item is
// worked at a time: the token passes the head register and each cell's token
// register, and the next item is accepted once its result is in the output
// register. The result waits in that output register while the next item is
// accepted; a result still held there stalls the chain once the next token
// reaches its end. start_of_image empties the palette as its item is accepted;
// there is no clearing pass after reset.
module palette_builder_indexer_top import pbi_pkg::*; #(
	parameter int unsigned PALETTE_ENTRIES = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic pix_valid,
	output logic pix_stall,
	input  pix_t pix,
	output logic res_valid,
	input  logic res_stall,
	output res_t res,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_data
);

	logic             fmt_q;
	logic             busy_q;
	logic [CNT_W-1:0] count_q;
	tok_t             head_q;
	logic             res_valid_q;
	res_t             res_q;

	tok_t             chain [PALETTE_ENTRIES+1];
	tok_t             tail;
	tok_t             head_nxt;
	logic             accept;
	logic             clear;
	logic             advance;
	logic             tail_done;
	logic [CNT_W-1:0] count_nxt;
	res_t             res_nxt;

	assign cfg_ready = 1'b1;
	assign pix_stall = busy_q;
	assign accept    = pix_valid && !busy_q;
	assign clear     = accept && (pix.command == CMD_PIXEL) && pix.start_of_image;
	assign tail      = chain[PALETTE_ENTRIES];
	assign advance   = !(tail.valid && res_valid_q && res_stall);
	assign tail_done = tail.valid && advance;
	assign chain[0]  = head_q;

	for (genvar g = 0; g < PALETTE_ENTRIES; g++) begin : g_cell
		pbi_cell #(.POS(g)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.clear   (clear),
			.tok_in  (chain[g]),
			.tok_out (chain[g+1])
		);
	end

	always_comb begin
		head_nxt       = '0;
		head_nxt.valid = 1'b1;
		head_nxt.color = pix.pixel_color;
		if (pix.command == CMD_READ) begin
			head_nxt.op  = OP_READ;
			head_nxt.idx = clut_to_entry(pix.slot);
		end else if (fmt_q == FMT_INDEXED) begin
			head_nxt.op = OP_LOOKUP;
		end else begin
			head_nxt.op = OP_DIRECT;
		end
	end

	always_comb begin
		count_nxt = tail.inserted ? count_q + CNT_W'(1) : count_q;
		res_nxt   = '0;
		res_nxt.color_count = count_nxt;
		case (tail.op)
			OP_DIRECT: begin
				res_nxt.color_out = halve_channels(tail.color);
			end
			OP_LOOKUP: begin
				res_nxt.pixel_index  = tail.found ? tail.idx : MISS_INDEX;
				res_nxt.pixel_missed = !tail.found;
			end
			OP_READ: begin
				res_nxt.color_out = tail.found ? halve_channels(tail.color) : '0;
			end
			default: begin
				res_nxt.color_count = count_nxt;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q       <= FMT_INDEXED;
			busy_q      <= 1'b0;
			count_q     <= '0;
			head_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				fmt_q <= cfg_data;
			end
			if (accept) begin
				busy_q <= 1'b1;
				head_q <= head_nxt;
			end else if (advance) begin
				head_q.valid <= 1'b0;
			end
			if (clear) begin
				count_q <= '0;
			end else if (tail_done) begin
				count_q <= count_nxt;
			end
			if (tail_done) begin
				busy_q      <= 1'b0;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tail_done) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

[rtl/core/pbi_checker.sv]
// ----------------------------------------------------------------------------
// pbi_checker
// Port-level checks for the palette builder and indexer.
// ----------------------------------------------------------------------------
module pbi_checker import pbi_pkg::*; #(
	parameter int unsigned PALETTE_ENTRIES = 256
) (
	input logic clk,
	input logic arst_n,
	input logic pix_valid,
	input logic pix_stall,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);

	localparam logic [CNT_W-1:0] FULL = CNT_W'(PALETTE_ENTRIES);

	a_stall_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_stall |=> pix_stall)
		else $error("input not stalled while an item is in flight");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result changed");

	a_miss_index: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.pixel_missed |->
			res.pixel_index == MISS_INDEX && res.color_out == '0)
		else $error("miss without miss index");

	a_miss_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.pixel_missed |-> res.color_count == FULL)
		else $error("miss while palette has room");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.color_count <= FULL)
		else $error("palette count beyond depth");

endmodule

bind palette_builder_indexer_top pbi_checker #(
	.PALETTE_ENTRIES(PALETTE_ENTRIES)
) u_pbi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pix_valid),
	.pix_stall (pix_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);
